### design/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform.
package hpt_pkg;

	localparam int NUM_COLS = 4;
	localparam int COL_WIDTH = 64;
	localparam int LANE_WIDTH = 16;
	localparam int FRAC_BITS = 16;
	localparam int CFG_IDX_WIDTH = 2;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_COLUMN_X = 2'd0,
		REG_COLUMN_Y = 2'd1,
		REG_COLUMN_Z = 2'd2,
		REG_COLUMN_W = 2'd3
	} cfg_reg_t;

	// Per-item control that travels beside the divider chain.
	typedef struct packed {
		logic valid;
		logic fault;
		logic neg_x;
		logic neg_y;
		logic neg_z;
	} ctl_t;

endpackage

### design/hpt_mac.sv
// Column dot product: point times one matrix column plus the row 3 term.
module hpt_mac #(
	parameter int COORD_WIDTH = 32,
	parameter int COEF_WIDTH = 16,
	parameter int SUM_WIDTH = 51
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] pz,
	input  logic [hpt_pkg::COL_WIDTH-1:0] col,
	output logic signed [SUM_WIDTH-1:0]   sum
);
	import hpt_pkg::*;

	localparam int PW = COORD_WIDTH + COEF_WIDTH;

	logic signed [COEF_WIDTH-1:0] c0, c1, c2, c3;
	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1;
	logic signed [SUM_WIDTH-1:0] t3_s1;

	assign c0 = col[0*LANE_WIDTH +: COEF_WIDTH];
	assign c1 = col[1*LANE_WIDTH +: COEF_WIDTH];
	assign c2 = col[2*LANE_WIDTH +: COEF_WIDTH];
	assign c3 = col[3*LANE_WIDTH +: COEF_WIDTH];

	// Register products, then add.
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= PW'(px) * PW'(c0);
			p1_s1 <= PW'(py) * PW'(c1);
			p2_s1 <= PW'(pz) * PW'(c2);
			t3_s1 <= SUM_WIDTH'(c3) <<< FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum <= SUM_WIDTH'(p0_s1) + SUM_WIDTH'(p1_s1) + SUM_WIDTH'(p2_s1) + t3_s1;
		end
	end

endmodule

### design/hpt_div_cell.sv
// One restoring-divide cell: one quotient bit for each of three dividends.
module hpt_div_cell #(
	parameter int NW = 67,
	parameter int DW = 51,
	parameter int QW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  hpt_pkg::ctl_t ctl_in,
	input  logic [DW-1:0] den_in,
	input  logic [NW-1:0] num_in [3],
	input  logic [DW:0]   rem_in [3],
	input  logic [QW-1:0] quo_in [3],
	input  logic          ovf_in [3],
	output hpt_pkg::ctl_t ctl_out,
	output logic [DW-1:0] den_out,
	output logic [NW-1:0] num_out [3],
	output logic [DW:0]   rem_out [3],
	output logic [QW-1:0] quo_out [3],
	output logic          ovf_out [3]
);
	import hpt_pkg::*;

	logic [DW+1:0] trial [3];
	logic [DW+1:0] diff [3];
	logic          take [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			trial[k] = {rem_in[k], num_in[k][NW-1]};
			diff[k] = trial[k] - {1'b0, 1'b0, den_in};
			take[k] = !diff[k][DW+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_out <= den_in;
			for (int k = 0; k < 3; k++) begin
				num_out[k] <= num_in[k] << 1;
				rem_out[k] <= take[k] ? diff[k][DW:0] : trial[k][DW:0];
				// A one shifted out of the quotient top marks overflow.
				ovf_out[k] <= ovf_in[k] | quo_in[k][QW-1];
				quo_out[k] <= {quo_in[k][QW-2:0], take[k]};
			end
		end
	end

endmodule

### design/homogeneous_point_transform_top.sv
// Top level: 4x4 homogeneous transform with a chain of divider cells.
// Path: column products, column sums, NW divider cells, result register; NW = COORD_WIDTH+COEF_WIDTH+19.
// Throughput: one item per cycle unless stalled; the whole pipe advances whenever the output can move.
// The divide runs one quotient bit per cell over a row of NW identical cells.
// Reset clears valid flags and loads the identity matrix; data registers are not reset.
module homogeneous_point_transform_top #(
	parameter int COORD_WIDTH = 32,
	parameter int COEF_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// point_x, point_y, point_z from bit 0 up
	input  logic [3*COORD_WIDTH-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// result_x, result_y, result_z from bit 0 up
	output logic [3*COORD_WIDTH-1:0] m_tdata,
	// divide_fault
	output logic                     m_tuser,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [hpt_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [hpt_pkg::COL_WIDTH-1:0]     cfg_data
);
	import hpt_pkg::*;

	localparam int SW = COORD_WIDTH + COEF_WIDTH + 3;   // sum width
	localparam int DW = SW;                             // magnitude width
	localparam int NW = DW + FRAC_BITS;                 // shifted dividend width
	localparam int QW = COORD_WIDTH + 1;
	localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
	localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (COORD_WIDTH - 1));

	logic en;
	logic [COL_WIDTH-1:0] col_q [NUM_COLS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q[REG_COLUMN_X] <= 64'd256;
			col_q[REG_COLUMN_Y] <= 64'd1 << 24;
			col_q[REG_COLUMN_Z] <= 64'd1 << 40;
			col_q[REG_COLUMN_W] <= 64'd1 << 56;
		end else if (cfg_valid) begin
			col_q[cfg_index] <= cfg_data;
		end
	end

	// Pipe advances together; output register acts as the single stall point.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [COORD_WIDTH-1:0] px, py, pz;
	assign px = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
	assign py = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
	assign pz = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];

	logic signed [SW-1:0] sum [NUM_COLS];
	genvar gc;
	generate
		for (gc = 0; gc < NUM_COLS; gc++) begin : g_mac
			hpt_mac #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH), .SUM_WIDTH(SW))
				u_mac (.clk(clk), .en(en), .px(px), .py(py), .pz(pz),
					.col(col_q[gc]), .sum(sum[gc]));
		end
	endgenerate

	logic v_s1, v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	// Sign split: magnitudes and result signs into the divider chain.
	ctl_t          ctl_c [NW+1];
	logic [DW-1:0] den_c [NW+1];
	logic [NW-1:0] num_c [NW+1][3];
	logic [DW:0]   rem_c [NW+1][3];
	logic [QW-1:0] quo_c [NW+1][3];
	logic          ovf_c [NW+1][3];

	logic [SW-1:0] wmag;
	logic          wneg;
	assign wneg = sum[REG_COLUMN_W][SW-1];
	assign wmag = wneg ? SW'(-sum[REG_COLUMN_W]) : SW'(sum[REG_COLUMN_W]);

	always_comb begin
		ctl_c[0].valid = v_s2;
		ctl_c[0].fault = (sum[REG_COLUMN_W] == '0);
		ctl_c[0].neg_x = sum[REG_COLUMN_X][SW-1] ^ wneg;
		ctl_c[0].neg_y = sum[REG_COLUMN_Y][SW-1] ^ wneg;
		ctl_c[0].neg_z = sum[REG_COLUMN_Z][SW-1] ^ wneg;
		den_c[0] = wmag;
		for (int k = 0; k < 3; k++) begin
			num_c[0][k] = {(sum[k][SW-1] ? SW'(-sum[k]) : SW'(sum[k])),
				{FRAC_BITS{1'b0}}};
			rem_c[0][k] = '0;
			quo_c[0][k] = '0;
			ovf_c[0][k] = 1'b0;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < NW; gi++) begin : g_cell
			hpt_div_cell #(.NW(NW), .DW(DW), .QW(QW)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.ctl_in(ctl_c[gi]), .den_in(den_c[gi]), .num_in(num_c[gi]),
				.rem_in(rem_c[gi]), .quo_in(quo_c[gi]), .ovf_in(ovf_c[gi]),
				.ctl_out(ctl_c[gi+1]), .den_out(den_c[gi+1]), .num_out(num_c[gi+1]),
				.rem_out(rem_c[gi+1]), .quo_out(quo_c[gi+1]), .ovf_out(ovf_c[gi+1]));
		end
	endgenerate

	// Saturate, apply sign, mask.
	logic [COORD_WIDTH-1:0] res [3];
	logic                   negk [3];
	always_comb begin
		negk[0] = ctl_c[NW].neg_x;
		negk[1] = ctl_c[NW].neg_y;
		negk[2] = ctl_c[NW].neg_z;
		for (int k = 0; k < 3; k++) begin
			logic [QW-1:0] q;
			q = quo_c[NW][k];
			if (negk[k]) begin
				if (ovf_c[NW][k] || q > LIM_NEG) q = LIM_NEG;
				res[k] = COORD_WIDTH'(-q);
			end else begin
				if (ovf_c[NW][k] || q > LIM_POS) q = LIM_POS;
				res[k] = COORD_WIDTH'(q);
			end
			if (ctl_c[NW].fault) res[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= ctl_c[NW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {res[2], res[1], res[0]};
			m_tuser <= ctl_c[NW].fault;
		end
	end

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("fault item carries nonzero data");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && m_tvalid)
		else $error("stalled result changed");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready out of step with output stall");

endmodule
